// File: sv/btex_pkg.sv
// Shared types and constants for the bilinear texture sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package btex_pkg;

  localparam int DIM_W       = 9;               // tex_width / tex_height
  localparam int COORD_W     = 18;              // signed Q2.16 coordinate
  localparam int FRAC_W      = 16;              // fraction bits of Q2.16
  localparam int UNIT_W      = FRAC_W + 1;      // clamped coordinate, 0 .. 1.0
  localparam int POS_W       = DIM_W + 1;       // integer part after scaling
  localparam int SCALED_W    = UNIT_W + DIM_W;  // coordinate times (size - 1)
  localparam int ROW_W       = POS_W + DIM_W + 1;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int TEXEL_W     = NUM_CH * CH_W;
  localparam int WADDR_W     = 16;
  localparam int OUT_W       = 24;
  localparam int LERP_W      = UNIT_W + CH_W;
  localparam int MIX_W       = UNIT_W + OUT_W;
  localparam int NUM_TAPS    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [UNIT_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [OUT_W-1:0]  OUT_MAX = 24'hFF0000;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } btex_op_t;

  // Texture size as seen by the datapath, already limited to the maximum.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] wm1;
    logic [DIM_W-1:0] hm1;
    logic             no_tex;
  } btex_dims_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic                is_sample;
    logic                no_tex;
    logic [SCALED_W-1:0] fx;
    logic [SCALED_W-1:0] fy;
    logic [WADDR_W-1:0]  waddr;
    logic [TEXEL_W-1:0]  texel;
  } btex_item_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QPTR_W:0] count;
  } btex_qstat_t;

endpackage

`default_nettype wire

// File: sv/btex_front.sv
// Front end: input register, item classification, coordinate clamp and scale.
// Depends on btex_pkg; feeds btex_queue.
`timescale 1ns / 1ps
`default_nettype none

module btex_front
  import btex_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  input  logic [WADDR_W-1:0]        texel_addr,
  input  logic [TEXEL_W-1:0]        texel,
  input  btex_dims_t                dims,
  input  logic                      q_full,
  output logic                      push,
  output btex_item_t                push_item
);

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic [COORD_W-1:0] raw);
    logic [UNIT_W-1:0] res;
    if (raw[COORD_W-1]) begin
      res = '0;
    end else if (raw[UNIT_W-1:0] > ONE_Q16) begin
      res = ONE_Q16;
    end else begin
      res = raw[UNIT_W-1:0];
    end
    return res;
  endfunction

  logic                 f_valid;
  btex_op_t             f_op;
  logic [COORD_W-1:0]   f_u;
  logic [COORD_W-1:0]   f_v;
  logic [WADDR_W-1:0]   f_addr;
  logic [TEXEL_W-1:0]   f_texel;
  logic                 accept;
  logic [UNIT_W-1:0]    u_c;
  logic [UNIT_W-1:0]    v_c;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op    <= btex_op_t'(opcode);
      f_u     <= coord_u;
      f_v     <= coord_v;
      f_addr  <= texel_addr;
      f_texel <= texel;
    end
  end

  always_comb begin
    u_c                 = clamp_unit(f_u);
    v_c                 = clamp_unit(f_v);
    push_item.is_sample = (f_op == OP_SAMPLE);
    push_item.no_tex    = dims.no_tex;
    push_item.fx        = SCALED_W'(u_c) * SCALED_W'(dims.wm1);
    push_item.fy        = SCALED_W'(v_c) * SCALED_W'(dims.hm1);
    push_item.waddr     = f_addr;
    push_item.texel     = f_texel;
  end

endmodule

`default_nettype wire

// File: sv/btex_queue.sv
// Short register FIFO that decouples the front end from the back end.
// Depends on btex_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module btex_queue
  import btex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  btex_item_t  push_item,
  input  logic        pop,
  output btex_item_t  head,
  output btex_qstat_t stat
);

  btex_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign stat.count = count;
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_next = count - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/btex_back.sv
// Back end: neighbor addresses, four texel store copies, two lerp stages, output register.
// Depends on btex_pkg; takes items from btex_queue.
`timescale 1ns / 1ps
`default_nettype none

module btex_back
  import btex_pkg::*;
#(
  parameter int STORE_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  btex_item_t       q_item,
  output logic             q_pop,
  input  btex_dims_t       dims,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] red_out,
  output logic [OUT_W-1:0] green_out,
  output logic [OUT_W-1:0] blue_out
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic en;

  // address stage
  logic [POS_W-1:0]  wm1_e, hm1_e;
  logic [POS_W-1:0]  x0_raw, y0_raw, x0, y0, x0_inc, y0_inc, x1, y1;
  logic [ROW_W-1:0]  row0, row1;
  logic [ADDR_W-1:0] tap_addr [NUM_TAPS];

  logic              s1_valid, s1_is_sample, s1_no_tex;
  logic [ADDR_W-1:0] s1_addr [NUM_TAPS];
  logic [ADDR_W-1:0] s1_waddr;
  logic [TEXEL_W-1:0] s1_texel;
  logic [FRAC_W-1:0] s1_tx, s1_ty;

  // memory stage
  logic [TEXEL_W-1:0] rd  [NUM_TAPS];
  logic              s2_valid, s2_is_sample, s2_no_tex;
  logic [FRAC_W-1:0] s2_tx, s2_ty;

  // horizontal blend
  logic [UNIT_W-1:0] wx_lo;
  logic [LERP_W-1:0] top_c [NUM_CH];
  logic [LERP_W-1:0] bot_c [NUM_CH];
  logic              s3_valid, s3_is_sample, s3_no_tex;
  logic [FRAC_W-1:0] s3_ty;
  logic [OUT_W-1:0]  s3_top [NUM_CH];
  logic [OUT_W-1:0]  s3_bot [NUM_CH];

  // vertical blend
  logic [UNIT_W-1:0] wy_lo;
  logic [MIX_W-1:0]  mix [NUM_CH];
  logic [OUT_W-1:0]  res [NUM_CH];

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_valid;

  always_comb begin
    wm1_e  = POS_W'(dims.wm1);
    hm1_e  = POS_W'(dims.hm1);
    x0_raw = q_item.fx[SCALED_W-1:FRAC_W];
    y0_raw = q_item.fy[SCALED_W-1:FRAC_W];
    x0     = (x0_raw > wm1_e) ? wm1_e : x0_raw;
    y0     = (y0_raw > hm1_e) ? hm1_e : y0_raw;
    x0_inc = x0 + POS_W'(1);
    y0_inc = y0 + POS_W'(1);
    x1     = (x0_inc < wm1_e) ? x0_inc : wm1_e;
    y1     = (y0_inc < hm1_e) ? y0_inc : hm1_e;
    row0   = ROW_W'(y0) * ROW_W'(dims.w);
    row1   = ROW_W'(y1) * ROW_W'(dims.w);
    // taps: 00, 10, 01, 11 as (x, y)
    tap_addr[0] = ADDR_W'(row0 + ROW_W'(x0));
    tap_addr[1] = ADDR_W'(row0 + ROW_W'(x1));
    tap_addr[2] = ADDR_W'(row1 + ROW_W'(x0));
    tap_addr[3] = ADDR_W'(row1 + ROW_W'(x1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_is_sample <= q_item.is_sample;
      s1_no_tex    <= q_item.no_tex;
      s1_waddr     <= ADDR_W'(q_item.waddr);
      s1_texel     <= q_item.texel;
      s1_tx        <= q_item.fx[FRAC_W-1:0];
      s1_ty        <= q_item.fy[FRAC_W-1:0];
      for (int k = 0; k < NUM_TAPS; k++) begin
        s1_addr[k] <= tap_addr[k];
      end
    end
  end

  // Every copy takes every write, so each tap gets its own read port.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_copy
    logic [TEXEL_W-1:0] copy_mem [STORE_DEPTH];

    always_ff @(posedge clk) begin
      if (en && s1_valid) begin
        if (s1_is_sample) begin
          rd[k] <= copy_mem[s1_addr[k]];
        end else begin
          copy_mem[s1_waddr] <= s1_texel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_is_sample <= s1_is_sample;
      s2_no_tex    <= s1_no_tex;
      s2_tx        <= s1_tx;
      s2_ty        <= s1_ty;
    end
  end

  always_comb begin
    wx_lo = ONE_Q16 - UNIT_W'(s2_tx);
    for (int c = 0; c < NUM_CH; c++) begin
      top_c[c] = LERP_W'(wx_lo) * LERP_W'(rd[0][TEXEL_W-1-CH_W*c -: CH_W]) +
                 LERP_W'(s2_tx) * LERP_W'(rd[1][TEXEL_W-1-CH_W*c -: CH_W]);
      bot_c[c] = LERP_W'(wx_lo) * LERP_W'(rd[2][TEXEL_W-1-CH_W*c -: CH_W]) +
                 LERP_W'(s2_tx) * LERP_W'(rd[3][TEXEL_W-1-CH_W*c -: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_is_sample <= s2_is_sample;
      s3_no_tex    <= s2_no_tex;
      s3_ty        <= s2_ty;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_top[c] <= top_c[c][OUT_W-1:0];
        s3_bot[c] <= bot_c[c][OUT_W-1:0];
      end
    end
  end

  always_comb begin
    wy_lo = ONE_Q16 - UNIT_W'(s3_ty);
    for (int c = 0; c < NUM_CH; c++) begin
      mix[c] = MIX_W'(wy_lo) * MIX_W'(s3_top[c]) + MIX_W'(s3_ty) * MIX_W'(s3_bot[c]);
      res[c] = s3_no_tex ? '0 : mix[c][FRAC_W +: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid && s3_is_sample) begin
      red_out   <= res[0];
      green_out <= res[1];
      blue_out  <= res[2];
    end
  end

endmodule

`default_nettype wire

// File: sv/bilinear_texture_sampler_core.sv
// Top level of the bilinear RGB8 texture sampler: config registers, front, queue, back.
// Depends on btex_pkg, btex_front, btex_queue and btex_back.
//
//   port group      dir  handshake            payload
//   input items     in   in_valid/in_stall    opcode, coord_u, coord_v, texel_addr,
//                                             texel_red, texel_green, texel_blue
//   result items    out  out_valid/out_stall  red_out, green_out, blue_out
//   config writes   in   cfg_we               cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; a sample raises out_valid after
// passing the front register, queue, address, store read, horizontal blend and vertical blend
// registers; a texel write gives none. Rate is set by the four copies of the texel store,
// one read port per bilinear tap, so all four neighbors are fetched in the same cycle.
// rst (synchronous) clears the config registers and every valid bit; the store is not
// cleared. out_stall freezes the back end; the 4-entry queue then fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_texture_sampler_core
  import btex_pkg::*;
#(
  parameter int MAX_DIM     = 256,
  parameter int STORE_DEPTH = 65536   // power of two; addresses wrap
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  input  logic [WADDR_W-1:0]        texel_addr,
  input  logic [CH_W-1:0]           texel_red,
  input  logic [CH_W-1:0]           texel_green,
  input  logic [CH_W-1:0]           texel_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_W-1:0]          red_out,
  output logic [OUT_W-1:0]          green_out,
  output logic [OUT_W-1:0]          blue_out
);

  logic [DIM_W-1:0] tex_width;
  logic [DIM_W-1:0] tex_height;
  logic [DIM_W-1:0] w_lim;
  logic [DIM_W-1:0] h_lim;
  btex_dims_t       dims;

  logic        q_push;
  btex_item_t  q_push_item;
  logic        q_pop;
  btex_item_t  q_head;
  btex_qstat_t q_stat;

  // Config registers. Writes outside the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= '0;
      tex_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Oversized dimensions count as MAX_DIM.
  always_comb begin
    w_lim       = (int'(tex_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : tex_width;
    h_lim       = (int'(tex_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : tex_height;
    dims.w      = w_lim;
    dims.wm1    = w_lim - DIM_W'(1);
    dims.hm1    = h_lim - DIM_W'(1);
    dims.no_tex = (w_lim == '0) || (h_lim == '0);
  end

  btex_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .coord_u    (coord_u),
    .coord_v    (coord_v),
    .texel_addr (texel_addr),
    .texel      ({texel_red, texel_green, texel_blue}),
    .dims       (dims),
    .q_full     (q_stat.full),
    .push       (q_push),
    .push_item  (q_push_item)
  );

  btex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  btex_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_stat.empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .dims      (dims),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  // A blend of bytes never exceeds 255.0 in Q8.16.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out <= OUT_MAX) && (green_out <= OUT_MAX) && (blue_out <= OUT_MAX))
    else $error("result above byte scale");

  // The input side only backs up when the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_stat.full)
    else $error("input stalled with room in queue");

  // The back end never takes from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Stall can only start right after an item was taken into the front register.
  a_stall_start: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("stall rose without a new item");

endmodule

`default_nettype wire

// File: verif/bilinear_texture_sampler_core_tb.sv
// Self-checking testbench for bilinear_texture_sampler_core: texel loads, bilinear samples,
// size registers, idling and back-pressure on both item channels.
// Depends on btex_pkg and the RTL of the sampler; nothing else.
`timescale 1ns / 1ps

module bilinear_texture_sampler_core_tb;
  import btex_pkg::*;

  localparam int TEX_MAX_DIM  = 256;
  localparam int STORE_WORDS  = 65536;
  localparam int QUIET_CYCLES = 12;     // extra wait after the last result so trailing writes drain too
  localparam int LONG_HOLD    = 200;    // receiver hold-off for the pressure test

  // Indexes past the two size registers; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    btex_op_t                   op;
    logic signed [COORD_W-1:0]  u;
    logic signed [COORD_W-1:0]  v;
    logic [WADDR_W-1:0]         addr;
    logic [CH_W-1:0]            r;
    logic [CH_W-1:0]            g;
    logic [CH_W-1:0]            b;
  } tex_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } shade_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DIM_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      opcode;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;
  logic [WADDR_W-1:0]        texel_addr;
  logic [CH_W-1:0]           texel_red;
  logic [CH_W-1:0]           texel_green;
  logic [CH_W-1:0]           texel_blue;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_W-1:0]          red_out;
  logic [OUT_W-1:0]          green_out;
  logic [OUT_W-1:0]          blue_out;

  // Shadow of the texture and the size registers, updated in acceptance order.
  logic [TEXEL_W-1:0] tex_model   [STORE_WORDS];
  bit                 tex_written [STORE_WORDS];
  logic [DIM_W-1:0]   model_w = '0;
  logic [DIM_W-1:0]   model_h = '0;

  shade_t expected_shades[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int sink_hold_cycles = 0;
  int fail_count = 0;
  int samples_checked = 0;
  int texel_writes = 0;
  int stall_seen = 0;

  bilinear_texture_sampler_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .texel_addr  (texel_addr),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] d);
    return (d > TEX_MAX_DIM) ? TEX_MAX_DIM : d;
  endfunction

  // Signed Q2.16 clamped to 0 .. 1.0
  function automatic int unsigned unit_coord(input logic [COORD_W-1:0] raw);
    if (raw[COORD_W-1]) return 0;
    if (raw > ONE_Q16) return ONE_Q16;
    return raw;
  endfunction

  function automatic shade_t blend_texels(input logic [COORD_W-1:0] u_raw,
                                          input logic [COORD_W-1:0] v_raw);
    int unsigned        w, h, fx, fy, x0, y0, x1, y1, tx, ty, sh;
    logic [TEXEL_W-1:0] taps [NUM_TAPS];
    longint unsigned    top, bot, mix;
    logic [OUT_W-1:0]   ch [NUM_CH];
    w = clip_dim(model_w);
    h = clip_dim(model_h);
    // no texture loaded: black
    if (w == 0 || h == 0) return '0;
    fx = unit_coord(u_raw) * (w - 1);
    fy = unit_coord(v_raw) * (h - 1);
    x0 = fx >> FRAC_W;
    y0 = fy >> FRAC_W;
    tx = fx & 'hFFFF;
    ty = fy & 'hFFFF;
    // right and lower neighbors stop at the last column / row
    x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    taps[0] = tex_model[WADDR_W'(y0 * w + x0)];
    taps[1] = tex_model[WADDR_W'(y0 * w + x1)];
    taps[2] = tex_model[WADDR_W'(y1 * w + x0)];
    taps[3] = tex_model[WADDR_W'(y1 * w + x1)];
    for (int k = 0; k < NUM_CH; k++) begin
      sh  = TEXEL_W - CH_W * (k + 1);
      top = (ONE_Q16 - tx) * taps[0][sh +: CH_W] + tx * taps[1][sh +: CH_W];
      bot = (ONE_Q16 - tx) * taps[2][sh +: CH_W] + tx * taps[3][sh +: CH_W];
      mix = (ONE_Q16 - ty) * top + ty * bot;
      ch[k] = mix[FRAC_W +: OUT_W];
    end
    return {ch[0], ch[1], ch[2]};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mix of the interesting points (0, 1.0, just under 1.0, negative, above 1.0) and any value in 0 .. 1.0.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_W'(ONE_Q16);
      2:       return {1'b1, 17'($urandom)};
      3:       return COORD_W'($urandom_range(65537, 131071));
      4:       return COORD_W'($urandom_range(65520, 65535));
      default: return COORD_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Unused fields of an item always carry junk.
  function automatic tex_item_t rand_item(input int unsigned area);
    tex_item_t it;
    it.u    = COORD_W'($urandom);
    it.v    = COORD_W'($urandom);
    it.addr = WADDR_W'($urandom);
    it.r    = CH_W'($urandom);
    it.g    = CH_W'($urandom);
    it.b    = CH_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.op = OP_WRITE;
      // half of the writes land inside the live texture to stress read-after-write
      if (area > 0 && $urandom_range(0, 1) == 1) it.addr = WADDR_W'($urandom_range(0, area - 1));
    end else begin
      it.op = OP_SAMPLE;
      it.u  = rand_coord();
      it.v  = rand_coord();
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then update the shadow state.
  task automatic push_item(input tex_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= it.op;
    coord_u     <= it.u;
    coord_v     <= it.v;
    texel_addr  <= it.addr;
    texel_red   <= it.r;
    texel_green <= it.g;
    texel_blue  <= it.b;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_WRITE) begin
      tex_model[it.addr]   = {it.r, it.g, it.b};
      tex_written[it.addr] = 1'b1;
      texel_writes++;
    end else begin
      expected_shades.push_back(blend_texels(it.u, it.v));
    end
    @(negedge clk);
  endtask

  task automatic texel_write(input logic [WADDR_W-1:0] addr, input logic [TEXEL_W-1:0] rgb);
    tex_item_t it;
    it = rand_item(0);
    it.op = OP_WRITE;
    it.addr = addr;
    {it.r, it.g, it.b} = rgb;
    push_item(it);
  endtask

  task automatic texel_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    tex_item_t it;
    it = rand_item(0);
    it.op = OP_SAMPLE;
    it.u = u;
    it.v = v;
    push_item(it);
  endtask

  // Drop valid and let every sample and trailing write leave the pipeline.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_shades.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Only called while quiet. Trailing negedge keeps back-to-back writes apart.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEX_WIDTH:  model_w = val;
      REG_TEX_HEIGHT: model_h = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // New size, then make sure every texel it can touch holds known data.
  // Small textures get fresh content; large ones only fill the holes.
  task automatic load_texture(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    int unsigned area;
    wait_quiet();
    set_reg(REG_TEX_WIDTH, w);
    set_reg(REG_TEX_HEIGHT, h);
    area = clip_dim(w) * clip_dim(h);
    for (int unsigned a = 0; a < area; a++)
      if (area <= 64 || !tex_written[a]) texel_write(WADDR_W'(a), TEXEL_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero width or height gives black; the reset state is exactly that.
  task automatic test_no_texture();
    texel_sample('0, '0);
    texel_sample(COORD_W'(ONE_Q16), 18'h08000);
    wait_quiet();
    set_reg(REG_TEX_WIDTH, 9'd0);
    set_reg(REG_TEX_HEIGHT, 9'd5);
    texel_sample(18'h04000, 18'h0C000);
    texel_sample(18'h1FFFF, 18'h20000);
    wait_quiet();
    set_reg(REG_TEX_WIDTH, 9'd3);
    set_reg(REG_TEX_HEIGHT, 9'd0);
    texel_sample(18'h08000, 18'h08000);
    texel_sample(COORD_W'(ONE_Q16), COORD_W'(ONE_Q16));
  endtask

  // 2x2 texture with corner colors; clamping and fraction extremes.
  task automatic test_corner_samples();
    logic [COORD_W-1:0] pts [9][2];
    pts = '{'{18'h00000, 18'h00000}, '{18'h10000, 18'h10000}, '{18'h1FFFF, 18'h1FFFF},
            '{18'h20000, 18'h3FFFF}, '{18'h08000, 18'h08000}, '{18'h0FFFF, 18'h0FFFF},
            '{18'h10000, 18'h00000}, '{18'h00000, 18'h10000}, '{18'h04000, 18'h0C000}};
    wait_quiet();
    set_reg(REG_TEX_WIDTH, 9'd2);
    set_reg(REG_TEX_HEIGHT, 9'd2);
    texel_write(16'd0, 24'h000000);
    texel_write(16'd1, 24'hFFFFFF);
    texel_write(16'd2, 24'hFF0000);
    texel_write(16'd3, 24'h00FF00);
    foreach (pts[i]) texel_sample(pts[i][0], pts[i][1]);
    // write immediately followed by a sample of the same texel
    tx_idle = 1'b0;
    texel_write(16'd1, 24'h0000FF);
    texel_sample(COORD_W'(ONE_Q16), '0);
    tx_idle = 1'b1;
  endtask

  // Sizes above the maximum count as the maximum; exact maximum too.
  task automatic test_oversized_dims();
    load_texture(9'd511, 9'd1);
    texel_sample(COORD_W'(ONE_Q16), COORD_W'(ONE_Q16));
    texel_sample(18'h0FFFF, 18'h00000);
    repeat (4) texel_sample(rand_coord(), rand_coord());
    load_texture(9'd256, 9'd1);
    texel_sample(COORD_W'(ONE_Q16), 18'h08000);
    repeat (3) texel_sample(rand_coord(), rand_coord());
    load_texture(9'd1, 9'd300);
    texel_sample(18'h08000, COORD_W'(ONE_Q16));
    repeat (3) texel_sample(rand_coord(), rand_coord());
  endtask

  // Writes to the two spare indexes must leave both sizes alone.
  task automatic test_unknown_index();
    load_texture(9'd3, 9'd2);
    wait_quiet();
    set_reg(REG_SPARE_A, 9'h1FF);
    set_reg(REG_SPARE_B, 9'h000);
    repeat (6) texel_sample(rand_coord(), rand_coord());
  endtask

  // Receiver freezes for a long stretch while items keep coming: queue fills,
  // in_stall must rise and nothing may be lost or duplicated.
  task automatic test_backpressure();
    load_texture(9'd4, 9'd4);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    repeat (40) push_item(rand_item(16));
  endtask

  // Phases of: new size, full load, then a random mix of samples and writes.
  task automatic test_random_mix();
    logic [DIM_W-1:0] w_sel, h_sel;
    int unsigned      area;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          w_sel = DIM_W'($urandom_range(200, 511));
          h_sel = 9'd1;
        end
        1: begin
          w_sel = 9'd1;
          h_sel = DIM_W'($urandom_range(200, 511));
        end
        2: begin
          w_sel = $urandom_range(0, 1) ? 9'd0 : DIM_W'($urandom_range(1, 8));
          h_sel = (w_sel == 0) ? DIM_W'($urandom_range(0, 511)) : 9'd0;
        end
        default: begin
          w_sel = DIM_W'($urandom_range(1, 12));
          h_sel = DIM_W'($urandom_range(1, 12));
        end
      endcase
      tx_idle = (ph % 3) != 0;
      rx_idle = (ph % 4) != 1;
      load_texture(w_sel, h_sel);
      area = clip_dim(w_sel) * clip_dim(h_sel);
      repeat (36) push_item(rand_item(area));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // One drawn hold-off per result; a requested long hold takes precedence.
  initial begin : result_sink
    int wait_n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        wait_n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_n = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  initial begin : result_check
    shade_t           want;
    logic [OUT_W-1:0] got_ch  [NUM_CH];
    logic [OUT_W-1:0] want_ch [NUM_CH];
    string            ch_name [NUM_CH];
    ch_name = '{"red_out", "green_out", "blue_out"};
    forever begin
      @(posedge clk);
      if (!rst && in_valid && in_stall) stall_seen++;
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (expected_shades.size() == 0) begin
          $display("%0t: result with none pending, got %h %h %h",
                   $time, red_out, green_out, blue_out);
          fail_count++;
        end else begin
          want = expected_shades.pop_front();
          want_ch = '{want.red, want.green, want.blue};
          got_ch  = '{red_out, green_out, blue_out};
          samples_checked++;
          for (int k = 0; k < NUM_CH; k++)
            if (got_ch[k] !== want_ch[k]) begin
              $display("%0t: %s mismatch, expected %h, actual %h",
                       $time, ch_name[k], want_ch[k], got_ch[k]);
              fail_count++;
            end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin : run
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_WRITE;
    coord_u     = '0;
    coord_v     = '0;
    texel_addr  = '0;
    texel_red   = '0;
    texel_green = '0;
    texel_blue  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_no_texture();
    test_corner_samples();
    test_oversized_dims();
    test_unknown_index();
    test_backpressure();
    test_random_mix();

    wait_quiet();
    repeat (20) @(posedge clk);
    if (expected_shades.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_shades.size());
      fail_count++;
    end
    $display("Checked %0d filtered samples against %0d texel loads, sizes 0 to 511.",
             samples_checked, texel_writes);
    $display("Input was held off %0d cycles by result back-pressure.", stall_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Far above the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
